// File: sv/assert_macros.svh
// Assertion macros used by the checker file xsf_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/xsf_pkg.sv
// Package: types, codes and defaults of the XOR sprite framebuffer.
`default_nettype none

package xsf_pkg;

  localparam int unsigned FrameWidthDefault  = 64;
  localparam int unsigned FrameHeightDefault = 32;
  localparam int unsigned PixOutWidth        = 64;

  typedef enum logic [1:0] {
    CMD_DRAW  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [3:0] row_index;
    logic [7:0] row_bits;
    logic       last_row;
  } xsf_in_t;

  typedef struct packed {
    logic                   collision;
    logic                   sprite_done;
    logic [PixOutWidth-1:0] row_pixels;
  } xsf_out_t;

  // Controller to datapath step commands.
  typedef struct packed {
    logic capture;  // latch the incoming command
    logic fetch;    // read the addressed row
    logic exec;     // modify, write back, load result
  } xsf_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_DONE  = 4'b1000
  } xsf_state_e;

endpackage

`default_nettype wire

// File: sv/xsf_ctrl.sv
// Sequencer: accept, fetch, execute, result strobe.
`default_nettype none

module xsf_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  output xsf_pkg::xsf_ctl_t  ctl_o
);

  xsf_pkg::xsf_state_e state_q, state_d;
  logic accept;

  assign busy   = !((state_q == xsf_pkg::ST_IDLE) || (state_q == xsf_pkg::ST_DONE));
  assign accept = start && !busy;
  assign done_o = (state_q == xsf_pkg::ST_DONE);

  assign ctl_o.capture = accept;
  assign ctl_o.fetch   = (state_q == xsf_pkg::ST_FETCH);
  assign ctl_o.exec    = (state_q == xsf_pkg::ST_EXEC);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      xsf_pkg::ST_IDLE:  state_d = accept ? xsf_pkg::ST_FETCH : xsf_pkg::ST_IDLE;
      xsf_pkg::ST_FETCH: state_d = xsf_pkg::ST_EXEC;
      xsf_pkg::ST_EXEC:  state_d = xsf_pkg::ST_DONE;
      xsf_pkg::ST_DONE:  state_d = accept ? xsf_pkg::ST_FETCH : xsf_pkg::ST_IDLE;
      default:           state_d = xsf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xsf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/xsf_datapath.sv
// Datapath: row memory, row valid bits, sprite XOR and collision flag.
`default_nettype none

module xsf_datapath #(
  parameter int unsigned FRAME_WIDTH  = xsf_pkg::FrameWidthDefault,
  parameter int unsigned FRAME_HEIGHT = xsf_pkg::FrameHeightDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire xsf_pkg::xsf_ctl_t ctl_i,
  input  wire xsf_pkg::xsf_in_t  cmd_i,
  output xsf_pkg::xsf_out_t      res_o
);

  localparam int unsigned RowW = $clog2(FRAME_HEIGHT);
  localparam int unsigned ColW = $clog2(FRAME_WIDTH);
  localparam logic [9:0]  Height10 = 10'(FRAME_HEIGHT);
  localparam logic [8:0]  Width9   = 9'(FRAME_WIDTH);
  localparam logic [ColW:0] WidthC = (ColW+1)'(FRAME_WIDTH);
  localparam logic [ColW-1:0] LastCol = ColW'(FRAME_WIDTH - 1);

  // Value below 271, height at least 32: four restoring steps.
  function automatic logic [RowW-1:0] wrap_row(input logic [9:0] v);
    logic [9:0] r;
    r = v;
    for (int k = 3; k >= 0; k--) begin
      if (r >= (Height10 << k)) r = r - (Height10 << k);
    end
    return r[RowW-1:0];
  endfunction

  // Value below 256, width at least 64: two restoring steps.
  function automatic logic [ColW-1:0] wrap_col(input logic [7:0] v);
    logic [8:0] r;
    r = {1'b0, v};
    for (int k = 1; k >= 0; k--) begin
      if (r >= (Width9 << k)) r = r - (Width9 << k);
    end
    return r[ColW-1:0];
  endfunction

  xsf_pkg::cmd_e     cmd_q;
  logic [RowW-1:0]   row_q;
  logic [ColW-1:0]   col_q;
  logic [7:0]        bits_q;
  logic              last_q;

  logic [FRAME_WIDTH-1:0]  mem_q [FRAME_HEIGHT];
  logic [FRAME_HEIGHT-1:0] valid_q, valid_d;
  logic [FRAME_WIDTH-1:0]  rd_data_q;
  logic                    rd_valid_q;
  logic                    seen_q, seen_d;
  xsf_pkg::xsf_out_t       res_q, res_d;

  logic [9:0]             row_sum;
  logic [FRAME_WIDTH-1:0] cur_row, mask, new_row;
  logic                   hit, coll_new;

  assign row_sum = {2'b00, cmd_i.start_y}
                 + ((cmd_i.command == xsf_pkg::CMD_DRAW) ? {6'd0, cmd_i.row_index} : 10'd0);

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q  <= cmd_i.command;
      row_q  <= wrap_row(row_sum);
      col_q  <= wrap_col(cmd_i.start_x);
      bits_q <= cmd_i.row_bits;
      last_q <= cmd_i.last_row;
    end
  end

  // Row memory: registered read in fetch, write-back in execute.
  always_ff @(posedge clk_i) begin
    if (ctl_i.fetch) begin
      rd_data_q  <= mem_q[row_q];
      rd_valid_q <= valid_q[row_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec && (cmd_q == xsf_pkg::CMD_DRAW)) begin
      mem_q[row_q] <= new_row;
    end
  end

  // Rows never written since reset or clear read as blank.
  assign cur_row = rd_valid_q ? rd_data_q : '0;

  always_comb begin
    logic [ColW:0]   col;
    logic [ColW-1:0] idx;
    mask = '0;
    for (int b = 0; b < 8; b++) begin
      col = {1'b0, col_q} + (ColW+1)'(b);
      if (col >= WidthC) col = col - WidthC;
      idx = LastCol - col[ColW-1:0];
      if (bits_q[7-b]) mask[idx] = 1'b1;
    end
  end

  assign new_row  = cur_row ^ mask;
  assign hit      = |(cur_row & mask);
  assign coll_new = seen_q | hit;

  always_comb begin
    valid_d = valid_q;
    seen_d  = seen_q;
    res_d   = res_q;
    if (ctl_i.exec) begin
      unique case (cmd_q)
        xsf_pkg::CMD_DRAW: begin
          valid_d[row_q]    = 1'b1;
          seen_d            = last_q ? 1'b0 : coll_new;
          res_d.collision   = coll_new;
          res_d.sprite_done = last_q;
          res_d.row_pixels  = new_row[FRAME_WIDTH-1 -: xsf_pkg::PixOutWidth];
        end
        xsf_pkg::CMD_CLEAR: begin
          valid_d           = '0;
          res_d.collision   = seen_q;
          res_d.sprite_done = 1'b0;
          res_d.row_pixels  = '0;
        end
        xsf_pkg::CMD_READ: begin
          res_d.collision   = seen_q;
          res_d.sprite_done = 1'b0;
          res_d.row_pixels  = cur_row[FRAME_WIDTH-1 -: xsf_pkg::PixOutWidth];
        end
        default: begin
          res_d = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      seen_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      seen_q  <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: sv/xor_sprite_framebuffer_unit.sv
// Top level of the monochrome XOR sprite framebuffer.
`default_nettype none

// Monochrome XOR sprite framebuffer, FRAME_WIDTH x FRAME_HEIGHT pixels.
// A command transfer happens on a rising edge with start high and busy low.
// Every command yields one result, shown on res_o for exactly one cycle
// while done_o is high; the receiver cannot stall, so it must take the
// result in that cycle. The result strobes once the command has passed
// capture, row fetch and modify/write-back, and busy drops in the
// strobe cycle, so a new command can be taken while the result is shown.
// Commands do not overlap further because each one does a
// read-modify-write of one frame row through the single-port row memory.
// Draw XORs the 8-pixel sprite row into frame row (start_y + row_index)
// mod FRAME_HEIGHT at columns start_x mod FRAME_WIDTH onward, wrapping;
// erasing a lit pixel sets the collision flag, which accumulates over a
// sprite and clears after the row marked last_row. Clear blanks the
// whole frame by dropping per-row valid bits; no clearing
// pass follows reset. Read returns row start_y mod FRAME_HEIGHT. Only
// the leftmost 64 columns appear on row_pixels (bit 63 = column 0).
// Command code 3 returns an all-zero result and changes nothing.
module xor_sprite_framebuffer_unit #(
  parameter int unsigned FRAME_WIDTH  = xsf_pkg::FrameWidthDefault,   // 64..128
  parameter int unsigned FRAME_HEIGHT = xsf_pkg::FrameHeightDefault   // 32..64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire xsf_pkg::xsf_in_t cmd_i,
  output logic                  done_o,
  output xsf_pkg::xsf_out_t     res_o
);

  // Step commands from the sequencer to the datapath.
  xsf_pkg::xsf_ctl_t ctl;

  xsf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .ctl_o  (ctl)
  );

  xsf_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .cmd_i  (cmd_i),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

// File: sv/xsf_checker.sv
// Port-level checker for the XOR sprite framebuffer, with its bind.
`default_nettype none

`include "assert_macros.svh"

module xsf_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic done_o
);

  logic accept;
  assign accept = start && !busy;

  // Every transfer is followed by its result strobe on done_o.
  `ASSERT_IMPL(a_result_latency, accept, ##3 done_o)
  // A transfer makes the unit busy at once.
  `ASSERT_NEXT(a_busy_after_accept, accept, busy)
  // Results never come back to back.
  `ASSERT_NEXT(a_single_strobe, done_o, !done_o)
  // A result never shows while the unit is busy.
  `ASSERT_IMPL(a_done_not_busy, done_o, !busy)

endmodule

bind xor_sprite_framebuffer_unit xsf_checker u_xsf_checker (.*);

`default_nettype wire
